@@ src/ssf_pkg.sv @@
package ssf_pkg;

  // Event codes
  typedef enum logic [3:0] {
    OP_POWER_ON      = 4'd0,
    OP_SELFTEST_OK   = 4'd1,
    OP_SELFTEST_FAIL = 4'd2,
    OP_TICK          = 4'd3,
    OP_SENSOR        = 4'd4,
    OP_LINK          = 4'd5,
    OP_DEADLINE      = 4'd6,
    OP_DIVERGE       = 4'd7,
    OP_CAUSE_CLEARED = 4'd8,
    OP_SECOND_FAULT  = 4'd9,
    OP_STOP          = 4'd10,
    OP_CLEAR         = 4'd11,
    OP_WATCHDOG      = 4'd12,
    OP_VIOLATION     = 4'd13,
    OP_REINIT        = 4'd14,
    OP_UNDEF         = 4'd15
  } op_t;

  // Supervisor mode, one-hot
  typedef enum logic [4:0] {
    MODE_INIT = 5'b00001,
    MODE_RUN  = 5'b00010,
    MODE_DEG  = 5'b00100,
    MODE_SAFE = 5'b01000,
    MODE_HALT = 5'b10000
  } mode_t;

  // Encoded mode on the result beat
  localparam logic [2:0] CODE_INIT = 3'd0;
  localparam logic [2:0] CODE_RUN  = 3'd1;
  localparam logic [2:0] CODE_DEG  = 3'd2;
  localparam logic [2:0] CODE_SAFE = 3'd3;
  localparam logic [2:0] CODE_HALT = 3'd4;

  // Fault flag bits
  localparam logic [8:0] F_WDOG    = 9'h001;
  localparam logic [8:0] F_INIT    = 9'h002;
  localparam logic [8:0] F_ESC     = 9'h004;
  localparam logic [8:0] F_INT     = 9'h008;
  localparam logic [8:0] F_OPSTOP  = 9'h010;
  localparam logic [8:0] F_SENSOR  = 9'h020;
  localparam logic [8:0] F_LINK    = 9'h040;
  localparam logic [8:0] F_TIMING  = 9'h080;
  localparam logic [8:0] F_DIVERGE = 9'h100;

  // Register map (word index)
  localparam logic [2:0] REG_INIT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_DEGRADE_MAX  = 3'd1;
  localparam logic [2:0] REG_RECOVER      = 3'd2;
  localparam logic [2:0] REG_SAFE_OUTPUT  = 3'd3;
  localparam logic [2:0] REG_NUMERATOR    = 3'd4;
  localparam logic [2:0] REG_DENOMINATOR  = 3'd5;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  typedef struct packed {
    logic [31:0]        init_timeout;
    logic [31:0]        degrade_max;
    logic [31:0]        recover;
    logic signed [31:0] safe_output;
    logic [15:0]        numerator;
    logic [15:0]        denominator;
  } cfg_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    SEQ_IDLE = 6'b000001,
    SEQ_EVAL = 6'b000010,
    SEQ_MUL  = 6'b000100,
    SEQ_DIV  = 6'b001000,
    SEQ_FIN  = 6'b010000,
    SEQ_LOAD = 6'b100000
  } seq_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic fin;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic deg_next;
    logic den_zero;
    logic div_last;
    logic out_free;
  } sts_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_INIT: c = CODE_INIT;
      MODE_RUN:  c = CODE_RUN;
      MODE_DEG:  c = CODE_DEG;
      MODE_SAFE: c = CODE_SAFE;
      MODE_HALT: c = CODE_HALT;
      default:   c = CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

@@ src/ssf_regs.sv @@
module ssf_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssf_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [ssf_pkg::DATA_BITS-1:0]  pwdata,
  output logic [ssf_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output ssf_pkg::cfg_t                  cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ssf_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_timeout <= 32'd1000;
      cfg.degrade_max  <= 32'd5000;
      cfg.recover      <= 32'd500;
      cfg.safe_output  <= 32'sd0;
      cfg.numerator    <= 16'd1;
      cfg.denominator  <= 16'd2;
    end else if (wr) begin
      case (idx)
        ssf_pkg::REG_INIT_TIMEOUT: cfg.init_timeout <= pwdata;
        ssf_pkg::REG_DEGRADE_MAX:  cfg.degrade_max  <= pwdata;
        ssf_pkg::REG_RECOVER:      cfg.recover      <= pwdata;
        ssf_pkg::REG_SAFE_OUTPUT:  cfg.safe_output  <= $signed(pwdata);
        ssf_pkg::REG_NUMERATOR:    cfg.numerator    <= pwdata[15:0];
        ssf_pkg::REG_DENOMINATOR:  cfg.denominator  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ssf_pkg::REG_INIT_TIMEOUT: prdata = cfg.init_timeout;
      ssf_pkg::REG_DEGRADE_MAX:  prdata = cfg.degrade_max;
      ssf_pkg::REG_RECOVER:      prdata = cfg.recover;
      ssf_pkg::REG_SAFE_OUTPUT:  prdata = cfg.safe_output;
      ssf_pkg::REG_NUMERATOR:    prdata = {16'd0, cfg.numerator};
      ssf_pkg::REG_DENOMINATOR:  prdata = {16'd0, cfg.denominator};
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ src/ssf_ctrl.sv @@
module ssf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssf_pkg::sts_t sts,
  output ssf_pkg::cmd_t cmd
);

  ssf_pkg::seq_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ssf_pkg::SEQ_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ssf_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ssf_pkg::SEQ_EVAL;
        end
      end
      ssf_pkg::SEQ_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.deg_next && !sts.den_zero) state_next = ssf_pkg::SEQ_MUL;
        else                               state_next = ssf_pkg::SEQ_LOAD;
      end
      ssf_pkg::SEQ_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ssf_pkg::SEQ_DIV;
      end
      ssf_pkg::SEQ_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ssf_pkg::SEQ_FIN;
      end
      ssf_pkg::SEQ_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ssf_pkg::SEQ_LOAD;
      end
      ssf_pkg::SEQ_LOAD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = ssf_pkg::SEQ_IDLE;
        end
      end
      default: state_next = ssf_pkg::SEQ_IDLE;
    endcase
  end

  assign in_stall = (state != ssf_pkg::SEQ_IDLE);

endmodule

@@ src/ssf_clamp.sv @@
// Degraded clamp: safe + trunc((desired - safe) * num / den), saturated.
// Restoring division on the magnitude, two quotient bits per cycle.
module ssf_clamp (
  input  logic                clk,
  input  ssf_pkg::cmd_t       cmd,
  input  logic signed [31:0]  desired,
  input  ssf_pkg::cfg_t       cfg,
  output logic                div_last,
  output logic                den_zero,
  output logic signed [31:0]  result
);

  localparam int DB     = 50;          // |product| < 2^48, padded to even
  localparam int STEPS  = DB / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam int SW     = DB + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32'sh7FFFFFFF);
  localparam logic signed [SW-1:0] SAT_LO = SW'(32'sh80000000);

  logic signed [32:0]   span;
  logic signed [DB-1:0] prod;
  logic [DB-1:0]        mag, mag_next;
  logic [15:0]          rem, rem_next;
  logic [16:0]          sh;
  logic                 neg;
  logic [CNT_W-1:0]     cnt;
  logic signed [SW-1:0] qs, sum;

  assign span     = 33'(desired) - 33'(cfg.safe_output);
  assign prod     = span * $signed({1'b0, cfg.numerator});
  assign den_zero = (cfg.denominator == 16'd0);
  assign div_last = (cnt == CNT_W'(STEPS - 1));

  always_comb begin
    rem_next = rem;
    mag_next = mag;
    sh       = '0;
    for (int k = 0; k < 2; k++) begin
      sh       = {rem_next, mag_next[DB-1]};
      mag_next = {mag_next[DB-2:0], 1'b0};
      if (sh >= {1'b0, cfg.denominator}) begin
        sh          = sh - {1'b0, cfg.denominator};
        mag_next[0] = 1'b1;
      end
      rem_next = sh[15:0];
    end
  end

  always_comb begin
    qs  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = SW'(cfg.safe_output) + qs;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      neg <= prod[DB-1];
      mag <= prod[DB-1] ? DB'(-prod) : DB'(prod);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.fin) begin
      if (sum > SAT_HI)      result <= 32'sh7FFFFFFF;
      else if (sum < SAT_LO) result <= 32'sh80000000;
      else                   result <= sum[31:0];
    end
  end

endmodule

@@ src/ssf_core.sv @@
// Supervisor state, event evaluation and result register.
module ssf_core #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ssf_pkg::cmd_t       cmd,
  input  ssf_pkg::cfg_t       cfg,
  input  logic [3:0]          operation,
  input  logic [31:0]         now_ms,
  input  logic signed [31:0]  desired_output,
  input  logic                carry_watchdog,
  input  logic                den_zero,
  input  logic signed [31:0]  clamp_result,
  output logic signed [31:0]  desired_q,
  output logic                deg_next,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          new_state,
  output logic                actuation_allowed,
  output logic signed [31:0]  drive_output,
  output logic [8:0]          fault_flags,
  output logic [31:0]         rejected_count,
  output logic [31:0]         transition_count
);

  localparam int TW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int CW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef struct packed {
    ssf_pkg::mode_t        mode;
    logic [8:0]            fm;
    logic                  sw;
    logic [TIME_BITS-1:0]  lt;
    logic [TIME_BITS-1:0]  ea;
    logic [TIME_BITS-1:0]  ca;
    logic [TIME_BITS-1:0]  isa;
    logic                  da;
    logic [COUNT_BITS-1:0] rt;
    logic [COUNT_BITS-1:0] tt;
  } sv_t;

  function automatic sv_t go(input sv_t s, input ssf_pkg::mode_t nx,
                             input logic [TIME_BITS-1:0] at);
    sv_t r;
    r      = s;
    r.mode = nx;
    r.ea   = at;
    r.tt   = s.tt + COUNT_BITS'(1);
    if (nx != ssf_pkg::MODE_DEG) begin
      r.da = 1'b0;
      r.ca = '0;
    end
    return r;
  endfunction

  ssf_pkg::op_t         op_q;
  logic [31:0]          now_q;
  logic                 carry_q;
  sv_t                  cur, s;
  logic [TW-1:0]        now_w;
  logic [TIME_BITS-1:0] t, dt, dt2;
  logic [CW-1:0]        rt_w, tt_w;

  assign now_w = TW'(now_q);
  assign t     = now_w[TIME_BITS-1:0];
  assign rt_w  = CW'(cur.rt);
  assign tt_w  = CW'(cur.tt);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= ssf_pkg::op_t'(operation);
      now_q     <= now_ms;
      desired_q <= desired_output;
      carry_q   <= carry_watchdog;
    end
  end

  // next supervisor state
  always_comb begin
    s   = cur;
    dt  = '0;
    dt2 = '0;
    if (op_q == ssf_pkg::OP_REINIT) begin
      s      = '0;
      s.mode = ssf_pkg::MODE_INIT;
      s.sw   = carry_q;
      s.fm   = carry_q ? ssf_pkg::F_WDOG : 9'd0;
    end else if (t < cur.lt) begin
      // time went backwards: halt, stamp with last good time
      s.fm = s.fm | ssf_pkg::F_INT;
      s    = go(s, ssf_pkg::MODE_HALT, cur.lt);
    end else begin
      s.lt = t;
      if (op_q == ssf_pkg::OP_VIOLATION) begin
        s.fm = s.fm | ssf_pkg::F_INT;
        s    = go(s, ssf_pkg::MODE_HALT, t);
      end else if (op_q == ssf_pkg::OP_WATCHDOG) begin
        s.sw  = 1'b1;
        s.fm  = s.fm | ssf_pkg::F_WDOG;
        s.isa = t;
        s     = go(s, ssf_pkg::MODE_INIT, t);
      end else if (op_q == ssf_pkg::OP_STOP &&
                   (cur.mode == ssf_pkg::MODE_RUN || cur.mode == ssf_pkg::MODE_DEG ||
                    cur.mode == ssf_pkg::MODE_INIT)) begin
        s.fm = s.fm | ssf_pkg::F_OPSTOP;
        s    = go(s, ssf_pkg::MODE_SAFE, t);
      end else begin
        case (cur.mode)
          ssf_pkg::MODE_INIT: begin
            if (op_q == ssf_pkg::OP_POWER_ON) begin
              s.isa = t;
              s.ea  = t;
            end else if (op_q == ssf_pkg::OP_SELFTEST_OK) begin
              s = go(s, ssf_pkg::MODE_RUN, t);
            end else if (op_q == ssf_pkg::OP_SELFTEST_FAIL) begin
              s.fm = s.fm | ssf_pkg::F_INIT;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end else if (op_q != ssf_pkg::OP_TICK) begin
              s.rt = s.rt + COUNT_BITS'(1);
            end
          end
          ssf_pkg::MODE_RUN: begin
            if (op_q == ssf_pkg::OP_SENSOR) begin
              s.fm = s.fm | ssf_pkg::F_SENSOR;
              s    = go(s, ssf_pkg::MODE_DEG, t);
            end else if (op_q == ssf_pkg::OP_LINK) begin
              s.fm = s.fm | ssf_pkg::F_LINK;
              s    = go(s, ssf_pkg::MODE_DEG, t);
            end else if (op_q == ssf_pkg::OP_DEADLINE) begin
              s.fm = s.fm | ssf_pkg::F_TIMING;
              s    = go(s, ssf_pkg::MODE_DEG, t);
            end else if (op_q == ssf_pkg::OP_DIVERGE) begin
              s.fm = s.fm | ssf_pkg::F_DIVERGE;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end else if (op_q != ssf_pkg::OP_TICK) begin
              s.rt = s.rt + COUNT_BITS'(1);
            end
          end
          ssf_pkg::MODE_DEG: begin
            if (op_q == ssf_pkg::OP_CAUSE_CLEARED) begin
              if (!cur.da) begin
                s.da = 1'b1;
                s.ca = t;
              end
            end else if (op_q == ssf_pkg::OP_SENSOR || op_q == ssf_pkg::OP_LINK ||
                         op_q == ssf_pkg::OP_DEADLINE) begin
              s.da = 1'b0;
              s.ca = '0;
              if (op_q == ssf_pkg::OP_LINK)          s.fm = s.fm | ssf_pkg::F_LINK;
              else if (op_q == ssf_pkg::OP_DEADLINE) s.fm = s.fm | ssf_pkg::F_TIMING;
              else                                   s.fm = s.fm | ssf_pkg::F_SENSOR;
            end else if (op_q == ssf_pkg::OP_SECOND_FAULT) begin
              s.fm = s.fm | ssf_pkg::F_ESC;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end else if (op_q == ssf_pkg::OP_DIVERGE) begin
              s.fm = s.fm | ssf_pkg::F_DIVERGE;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end else if (op_q != ssf_pkg::OP_TICK) begin
              s.rt = s.rt + COUNT_BITS'(1);
            end
          end
          ssf_pkg::MODE_SAFE: begin
            if (op_q == ssf_pkg::OP_CLEAR) begin
              s.fm  = cur.sw ? ssf_pkg::F_WDOG : 9'd0;
              s.isa = t;
              s     = go(s, ssf_pkg::MODE_INIT, t);
            end else if (op_q != ssf_pkg::OP_TICK) begin
              s.rt = s.rt + COUNT_BITS'(1);
            end
          end
          default: begin
            if (op_q != ssf_pkg::OP_TICK) s.rt = s.rt + COUNT_BITS'(1);
          end
        endcase

        // timers, on the mode just reached
        case (s.mode)
          ssf_pkg::MODE_INIT: begin
            dt = t - s.isa;
            if (TW'(dt) >= TW'(cfg.init_timeout)) begin
              s.fm = s.fm | ssf_pkg::F_INIT;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end
          end
          ssf_pkg::MODE_DEG: begin
            dt  = t - s.ea;
            dt2 = t - s.ca;
            if (TW'(dt) >= TW'(cfg.degrade_max)) begin
              s.fm = s.fm | ssf_pkg::F_ESC;
              s    = go(s, ssf_pkg::MODE_SAFE, t);
            end else if (s.da && TW'(dt2) >= TW'(cfg.recover)) begin
              s.fm = s.fm & ssf_pkg::F_WDOG;
              s    = go(s, ssf_pkg::MODE_RUN, t);
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign deg_next = (s.mode == ssf_pkg::MODE_DEG);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) cur <= '{mode: ssf_pkg::MODE_INIT, default: '0};
    else if (cmd.eval) cur <= s;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)           out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_state         <= ssf_pkg::mode_code(cur.mode);
      actuation_allowed <= (cur.mode == ssf_pkg::MODE_RUN) ||
                           (cur.mode == ssf_pkg::MODE_DEG);
      if (cur.mode == ssf_pkg::MODE_RUN)                   drive_output <= desired_q;
      else if (cur.mode == ssf_pkg::MODE_DEG && !den_zero) drive_output <= clamp_result;
      else                                                 drive_output <= cfg.safe_output;
      fault_flags       <= cur.fm;
      rejected_count    <= rt_w[31:0];
      transition_count  <= tt_w[31:0];
    end
  end

endmodule

@@ src/safety_supervisor_fsm.sv @@
// Channel   Direction  Handshake            Beat contents
// in        sink       in_valid / in_stall  operation, now_ms, desired_output, carry_watchdog
// out       source     out_valid/out_stall  new_state, actuation_allowed, drive_output,
//                                           fault_flags, rejected_count, transition_count
// cfg       APB slave  psel/penable/pready  six registers at byte address 4*i
//
// One beat at a time. A beat goes from eval straight to load when the new
// mode is not degraded or the clamp denominator is zero; otherwise it passes
// the clamp multiply, the restoring divider (two quotient bits per cycle)
// and a finish step first. Synchronous active-high rst restores
// register defaults and the init mode. The result register lets the next beat
// be taken while the last result is stalled; the sequencer waits only if a new
// result is ready first.
module safety_supervisor_fsm #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [3:0]                    operation,
  input  logic [31:0]                   now_ms,
  input  logic signed [31:0]            desired_output,
  input  logic                          carry_watchdog,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    new_state,
  output logic                          actuation_allowed,
  output logic signed [31:0]            drive_output,
  output logic [8:0]                    fault_flags,
  output logic [31:0]                   rejected_count,
  output logic [31:0]                   transition_count,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssf_pkg::ADDR_BITS-1:0] paddr,
  input  logic [ssf_pkg::DATA_BITS-1:0] pwdata,
  output logic [ssf_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  ssf_pkg::cfg_t      cfg;
  ssf_pkg::cmd_t      cmd;
  ssf_pkg::sts_t      sts;
  logic signed [31:0] desired_q;
  logic signed [31:0] clamp_result;
  logic               deg_next;
  logic               out_free;
  logic               den_zero;
  logic               div_last;

  // status gathered from core and clamp for the sequencer
  assign sts = '{deg_next: deg_next, den_zero: den_zero,
                 div_last: div_last, out_free: out_free};

  ssf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle -> eval -> (mul -> div x25 -> fin) -> load
  ssf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // supervisor mode, flags, timestamps, counters, result register
  ssf_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .operation         (operation),
    .now_ms            (now_ms),
    .desired_output    (desired_output),
    .carry_watchdog    (carry_watchdog),
    .den_zero          (den_zero),
    .clamp_result      (clamp_result),
    .desired_q         (desired_q),
    .deg_next          (deg_next),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .new_state         (new_state),
    .actuation_allowed (actuation_allowed),
    .drive_output      (drive_output),
    .fault_flags       (fault_flags),
    .rejected_count    (rejected_count),
    .transition_count  (transition_count)
  );

  // degraded-mode scaling about the safe value
  ssf_clamp u_clamp (
    .clk      (clk),
    .cmd      (cmd),
    .desired  (desired_q),
    .cfg      (cfg),
    .div_last (div_last),
    .den_zero (den_zero),
    .result   (clamp_result)
  );

endmodule

@@ dv/tb_safety_supervisor_fsm.sv @@
module tb_safety_supervisor_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [3:0]                    operation;
  logic [31:0]                   now_ms;
  logic signed [31:0]            desired_output;
  logic                          carry_watchdog;
  logic                          out_valid;
  logic                          out_stall;
  logic [2:0]                    new_state;
  logic                          actuation_allowed;
  logic signed [31:0]            drive_output;
  logic [8:0]                    fault_flags;
  logic [31:0]                   rejected_count;
  logic [31:0]                   transition_count;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ssf_pkg::ADDR_BITS-1:0] paddr;
  logic [ssf_pkg::DATA_BITS-1:0] pwdata;
  logic [ssf_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  safety_supervisor_fsm DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .now_ms            (now_ms),
    .desired_output    (desired_output),
    .carry_watchdog    (carry_watchdog),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .new_state         (new_state),
    .actuation_allowed (actuation_allowed),
    .drive_output      (drive_output),
    .fault_flags       (fault_flags),
    .rejected_count    (rejected_count),
    .transition_count  (transition_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Expected result beats, oldest first
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]         state;
    logic               allowed;
    logic signed [31:0] drive;
    logic [8:0]         flags;
    logic [31:0]        rejected;
    logic [31:0]        transitions;
  } verdict_t;

  verdict_t verdicts_due[$];

  int mismatches;
  int beats_seen;

  // idle knobs, percent chance per beat/cycle; hold_cycles forces a long stall
  int gap_pct;
  int stall_pct;
  int hold_cycles;

  // ---------------------------------------------------------------------------
  // Supervisor model: configuration copy and state
  // ---------------------------------------------------------------------------
  logic [31:0]        c_init_to, c_deg_max, c_recover;
  logic signed [31:0] c_safe;
  logic [15:0]        c_num, c_den;

  logic [2:0]  m_mode;
  logic [8:0]  m_flags;
  logic        m_wdog;
  logic [31:0] m_last, m_entered, m_cleared, m_init_start;
  logic        m_dwell;
  logic [31:0] m_rej, m_trans;

  function automatic void clear_supervisor(logic carry);
    m_mode       = ssf_pkg::CODE_INIT;
    m_wdog       = carry;
    m_flags      = carry ? ssf_pkg::F_WDOG : '0;
    m_last       = '0;
    m_entered    = '0;
    m_cleared    = '0;
    m_init_start = '0;
    m_dwell      = 1'b0;
    m_rej        = '0;
    m_trans      = '0;
  endfunction

  function automatic void enter_mode(logic [2:0] next, logic [31:0] t);
    m_mode    = next;
    m_entered = t;
    m_trans   = m_trans + 1;
    // the recover dwell only lives inside degraded
    if (next != ssf_pkg::CODE_DEG) begin
      m_dwell   = 1'b0;
      m_cleared = '0;
    end
  endfunction

  function automatic void enter_safe(logic [8:0] flag, logic [31:0] t);
    m_flags = m_flags | flag;
    enter_mode(ssf_pkg::CODE_SAFE, t);
  endfunction

  function automatic void enter_halt(logic [31:0] t);
    m_flags = m_flags | ssf_pkg::F_INT;
    enter_mode(ssf_pkg::CODE_HALT, t);
  endfunction

  function automatic void load_setting(logic [2:0] index, logic [31:0] value);
    case (index)
      ssf_pkg::REG_INIT_TIMEOUT: c_init_to = value;
      ssf_pkg::REG_DEGRADE_MAX:  c_deg_max = value;
      ssf_pkg::REG_RECOVER:      c_recover = value;
      ssf_pkg::REG_SAFE_OUTPUT:  c_safe    = value;
      ssf_pkg::REG_NUMERATOR:    c_num     = value[15:0];
      ssf_pkg::REG_DENOMINATOR:  c_den     = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] setting_value(logic [2:0] index);
    case (index)
      ssf_pkg::REG_INIT_TIMEOUT: return c_init_to;
      ssf_pkg::REG_DEGRADE_MAX:  return c_deg_max;
      ssf_pkg::REG_RECOVER:      return c_recover;
      ssf_pkg::REG_SAFE_OUTPUT:  return c_safe;
      ssf_pkg::REG_NUMERATOR:    return {16'b0, c_num};
      ssf_pkg::REG_DENOMINATOR:  return {16'b0, c_den};
      default:                   return '0;
    endcase
  endfunction

  // Apply one event to the model and return the result beat it causes.
  function automatic verdict_t supervise(ssf_pkg::op_t op, logic [31:0] t,
                                         logic signed [31:0] want_drive, logic carry);
    verdict_t    v;
    logic [8:0]  cause_flag;
    logic [31:0] age;
    longint      safe_l, span, num_l, den_l, scaled;

    case (op)
      ssf_pkg::OP_LINK:     cause_flag = ssf_pkg::F_LINK;
      ssf_pkg::OP_DEADLINE: cause_flag = ssf_pkg::F_TIMING;
      default:              cause_flag = ssf_pkg::F_SENSOR;
    endcase

    // reinit acts as a reset and beats the time guard
    if (op == ssf_pkg::OP_REINIT) begin
      clear_supervisor(carry);
    end else if (t < m_last) begin
      // time went backwards: halt, stamp with the last good time, no timers
      enter_halt(m_last);
    end else begin
      m_last = t;
      if (op == ssf_pkg::OP_VIOLATION) begin
        enter_halt(t);
      end else if (op == ssf_pkg::OP_WATCHDOG) begin
        // from every state, fault halt included
        m_wdog       = 1'b1;
        m_flags      = m_flags | ssf_pkg::F_WDOG;
        m_init_start = t;
        enter_mode(ssf_pkg::CODE_INIT, t);
      end else if (op == ssf_pkg::OP_STOP &&
                   (m_mode == ssf_pkg::CODE_RUN || m_mode == ssf_pkg::CODE_DEG ||
                    m_mode == ssf_pkg::CODE_INIT)) begin
        enter_safe(ssf_pkg::F_OPSTOP, t);
      end else begin
        case (m_mode)
          ssf_pkg::CODE_INIT: begin
            if (op == ssf_pkg::OP_POWER_ON) begin
              m_init_start = t;
              m_entered    = t;
            end else if (op == ssf_pkg::OP_SELFTEST_OK) begin
              enter_mode(ssf_pkg::CODE_RUN, t);
            end else if (op == ssf_pkg::OP_SELFTEST_FAIL) begin
              enter_safe(ssf_pkg::F_INIT, t);
            end else if (op != ssf_pkg::OP_TICK) begin
              m_rej = m_rej + 1;
            end
          end
          ssf_pkg::CODE_RUN: begin
            if (op == ssf_pkg::OP_SENSOR || op == ssf_pkg::OP_LINK ||
                op == ssf_pkg::OP_DEADLINE) begin
              m_flags = m_flags | cause_flag;
              enter_mode(ssf_pkg::CODE_DEG, t);
            end else if (op == ssf_pkg::OP_DIVERGE) begin
              enter_safe(ssf_pkg::F_DIVERGE, t);
            end else if (op != ssf_pkg::OP_TICK) begin
              m_rej = m_rej + 1;
            end
          end
          ssf_pkg::CODE_DEG: begin
            if (op == ssf_pkg::OP_CAUSE_CLEARED) begin
              // a second clear does not restart a running dwell
              if (!m_dwell) begin
                m_dwell   = 1'b1;
                m_cleared = t;
              end
            end else if (op == ssf_pkg::OP_SENSOR || op == ssf_pkg::OP_LINK ||
                         op == ssf_pkg::OP_DEADLINE) begin
              m_dwell   = 1'b0;
              m_cleared = '0;
              m_flags   = m_flags | cause_flag;
            end else if (op == ssf_pkg::OP_SECOND_FAULT) begin
              enter_safe(ssf_pkg::F_ESC, t);
            end else if (op == ssf_pkg::OP_DIVERGE) begin
              enter_safe(ssf_pkg::F_DIVERGE, t);
            end else if (op != ssf_pkg::OP_TICK) begin
              m_rej = m_rej + 1;
            end
          end
          ssf_pkg::CODE_SAFE: begin
            if (op == ssf_pkg::OP_CLEAR) begin
              m_flags      = m_wdog ? ssf_pkg::F_WDOG : '0;
              m_init_start = t;
              enter_mode(ssf_pkg::CODE_INIT, t);
            end else if (op != ssf_pkg::OP_TICK) begin
              m_rej = m_rej + 1;
            end
          end
          default: begin
            if (op != ssf_pkg::OP_TICK) m_rej = m_rej + 1;
          end
        endcase

        // timers, all on wrapping differences
        if (m_mode == ssf_pkg::CODE_INIT) begin
          age = t - m_init_start;
          if (age >= c_init_to) enter_safe(ssf_pkg::F_INIT, t);
        end else if (m_mode == ssf_pkg::CODE_DEG) begin
          age = t - m_entered;
          if (age >= c_deg_max) begin
            enter_safe(ssf_pkg::F_ESC, t);
          end else begin
            age = t - m_cleared;
            if (m_dwell && age >= c_recover) begin
              m_flags = m_flags & ssf_pkg::F_WDOG;
              enter_mode(ssf_pkg::CODE_RUN, t);
            end
          end
        end
      end
    end

    // drive: pass in run, scale about safe in degraded, else safe
    safe_l = longint'(c_safe);
    span   = longint'(want_drive) - safe_l;
    num_l  = longint'(c_num);
    den_l  = longint'(c_den);
    scaled = safe_l;
    if (den_l != 0) scaled = safe_l + (span * num_l) / den_l;
    if (scaled > 64'sd2147483647) scaled = 64'sd2147483647;
    if (scaled < -64'sd2147483648) scaled = -64'sd2147483648;

    v.state       = m_mode;
    v.allowed     = (m_mode == ssf_pkg::CODE_RUN) || (m_mode == ssf_pkg::CODE_DEG);
    v.drive       = (m_mode == ssf_pkg::CODE_RUN) ? want_drive :
                    (m_mode == ssf_pkg::CODE_DEG) ? scaled[31:0] : c_safe;
    v.flags       = m_flags;
    v.rejected    = m_rej;
    v.transitions = m_trans;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                           beats_seen, name, got, want));
  endtask

  // mostly short idle runs, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Offer one input beat; valid stays up after acceptance so the next call
  // can follow back-to-back. The model is stepped at the accepting edge.
  task automatic send_event(ssf_pkg::op_t op, logic [31:0] t, logic signed [31:0] d,
                            logic cw);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    now_ms         <= t;
    desired_output <= d;
    carry_watchdog <= cw;
    do @(posedge clk); while (in_stall);
    verdicts_due.push_back(supervise(op, t, d, cw));
  endtask

  // Drop valid, wait for every outstanding beat to come back, then idle on.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    load_setting(index, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_register(logic [2:0] index, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {index, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] init_to, logic [31:0] deg_max,
                                logic [31:0] recover, logic [31:0] safe,
                                logic [31:0] num, logic [31:0] den);
    write_register(ssf_pkg::REG_INIT_TIMEOUT, init_to);
    write_register(ssf_pkg::REG_DEGRADE_MAX, deg_max);
    write_register(ssf_pkg::REG_RECOVER, recover);
    write_register(ssf_pkg::REG_SAFE_OUTPUT, safe);
    write_register(ssf_pkg::REG_NUMERATOR, num);
    write_register(ssf_pkg::REG_DENOMINATOR, den);
  endtask

  task automatic check_registers();
    logic [31:0] got;
    for (int i = ssf_pkg::REG_INIT_TIMEOUT; i <= ssf_pkg::REG_DENOMINATOR; i++) begin
      read_register(i[2:0], got);
      if (got !== setting_value(i[2:0]))
        flag_error($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                             i, got, setting_value(i[2:0])));
    end
  endtask

  // Pick an event that mostly makes sense for the current mode, so random
  // runs get through init into run/degraded; the rest is noise.
  function automatic ssf_pkg::op_t pick_event();
    ssf_pkg::op_t pool[$];
    int           r;
    r = $urandom_range(99);
    if (r < 6) return ssf_pkg::op_t'($urandom_range(15));
    if (r < 8) return ssf_pkg::OP_REINIT;
    if (r < 9) return ssf_pkg::OP_WATCHDOG;
    if (r < 10) return ssf_pkg::OP_VIOLATION;
    // close to the top of the time range: start over before it wraps
    if (m_last > 32'hC000_0000 && r < 50) return ssf_pkg::OP_REINIT;
    case (m_mode)
      ssf_pkg::CODE_INIT: pool = '{ssf_pkg::OP_POWER_ON, ssf_pkg::OP_SELFTEST_OK,
                                   ssf_pkg::OP_SELFTEST_OK, ssf_pkg::OP_SELFTEST_OK,
                                   ssf_pkg::OP_SELFTEST_FAIL, ssf_pkg::OP_TICK,
                                   ssf_pkg::OP_STOP};
      ssf_pkg::CODE_RUN:  pool = '{ssf_pkg::OP_SENSOR, ssf_pkg::OP_LINK,
                                   ssf_pkg::OP_DEADLINE, ssf_pkg::OP_TICK,
                                   ssf_pkg::OP_TICK, ssf_pkg::OP_DIVERGE,
                                   ssf_pkg::OP_STOP};
      ssf_pkg::CODE_DEG:  pool = '{ssf_pkg::OP_CAUSE_CLEARED, ssf_pkg::OP_CAUSE_CLEARED,
                                   ssf_pkg::OP_TICK, ssf_pkg::OP_TICK, ssf_pkg::OP_TICK,
                                   ssf_pkg::OP_SENSOR, ssf_pkg::OP_LINK,
                                   ssf_pkg::OP_DEADLINE, ssf_pkg::OP_SECOND_FAULT,
                                   ssf_pkg::OP_DIVERGE, ssf_pkg::OP_STOP};
      ssf_pkg::CODE_SAFE: pool = '{ssf_pkg::OP_CLEAR, ssf_pkg::OP_CLEAR,
                                   ssf_pkg::OP_CLEAR, ssf_pkg::OP_TICK,
                                   ssf_pkg::OP_POWER_ON};
      default:            pool = '{ssf_pkg::OP_WATCHDOG, ssf_pkg::OP_REINIT,
                                   ssf_pkg::OP_TICK};
    endcase
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // Time mostly creeps forward at timer scale; big jumps may wrap, and a
  // few beats go backwards on purpose.
  task automatic send_random_event();
    ssf_pkg::op_t op;
    logic [31:0]  step_ms;
    logic [31:0]  t;
    int           r;
    op = pick_event();
    r  = $urandom_range(99);
    if (r < 55)      step_ms = $urandom_range(0, 20);
    else if (r < 85) step_ms = $urandom_range(0, 700);
    else if (r < 97) step_ms = $urandom_range(0, 8000);
    else             step_ms = $urandom;
    t = m_last + step_ms;
    if ($urandom_range(49) == 0 && m_last != 0) t = $urandom_range(0, m_last - 1);
    send_event(op, t, $urandom, 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, all-ones and low extremes through the APB port, then back
  // to the reset defaults for the event walk.
  task automatic test_register_access();
    check_registers();
    apply_settings('1, '1, '1, 32'h7FFF_FFFF, '1, '1);
    check_registers();
    apply_settings('0, '0, '0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001);
    check_registers();
    apply_settings(32'd1000, 32'd5000, 32'd500, '0, 32'd1, 32'd2);
    check_registers();
  endtask

  // Every event code and every mode, with the reset register values.
  task automatic test_event_walk();
    gap_pct   = 30;
    stall_pct = 30;
    // rejected in init
    send_event(ssf_pkg::OP_UNDEF,         32'd0,    32'sh7FFF_FFFF, 1'b0);
    // restamp init
    send_event(ssf_pkg::OP_POWER_ON,      32'd10,   32'sd5,         1'b0);
    send_event(ssf_pkg::OP_TICK,          32'd20,   32'sd5,         1'b1);
    // run passes drive
    send_event(ssf_pkg::OP_SELFTEST_OK,   32'd30,   32'sh8000_0000, 1'b0);
    // clamp truncates toward zero
    send_event(ssf_pkg::OP_SENSOR,        32'd40,   -32'sd7,        1'b0);
    send_event(ssf_pkg::OP_LINK,          32'd50,   -32'sd7,        1'b0);
    send_event(ssf_pkg::OP_DEADLINE,      32'd60,   32'sd1001,      1'b0);
    // dwell starts, then is not restarted
    send_event(ssf_pkg::OP_CAUSE_CLEARED, 32'd100,  32'sd9,         1'b0);
    send_event(ssf_pkg::OP_CAUSE_CLEARED, 32'd200,  32'sd9,         1'b0);
    // dwell done: run
    send_event(ssf_pkg::OP_TICK,          32'd600,  32'sd9,         1'b0);
    send_event(ssf_pkg::OP_DEADLINE,      32'd700,  32'sd3,         1'b0);
    // escalate
    send_event(ssf_pkg::OP_SECOND_FAULT,  32'd800,  32'sd3,         1'b0);
    // rejected in safe stop
    send_event(ssf_pkg::OP_POWER_ON,      32'd900,  32'sd3,         1'b0);
    send_event(ssf_pkg::OP_CLEAR,         32'd1000, 32'sd3,         1'b0);
    // operator stop in init
    send_event(ssf_pkg::OP_STOP,          32'd1100, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_CLEAR,         32'd1200, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_SELFTEST_FAIL, 32'd1300, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_CLEAR,         32'd1400, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_SELFTEST_OK,   32'd1500, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_DIVERGE,       32'd1600, 32'sd3,         1'b0);
    // sticky watchdog
    send_event(ssf_pkg::OP_WATCHDOG,      32'd1700, 32'sd3,         1'b0);
    // time backwards: halt
    send_event(ssf_pkg::OP_TICK,          32'd1000, 32'sd3,         1'b0);
    // watchdog leaves halt
    send_event(ssf_pkg::OP_WATCHDOG,      32'd1800, 32'sd3,         1'b0);
    send_event(ssf_pkg::OP_VIOLATION,     32'd1900, 32'sd3,         1'b0);
    // keep watchdog
    send_event(ssf_pkg::OP_REINIT,        '1,       32'sd3,         1'b1);
    // init timeout
    send_event(ssf_pkg::OP_TICK,          '1,       32'sd3,         1'b0);
  endtask

  // Full-scale clamp: saturation both ways, then the degraded limit.
  task automatic test_degraded_clamp();
    wait_for_results();
    apply_settings(32'd1000, 32'd5000, 32'd500, '0, 32'd65535, 32'd1);
    gap_pct   = 0;
    stall_pct = 0;
    send_event(ssf_pkg::OP_REINIT,      32'd0,    32'sd0,         1'b0);
    send_event(ssf_pkg::OP_SELFTEST_OK, 32'd1,    32'sd0,         1'b0);
    send_event(ssf_pkg::OP_SENSOR,      32'd2,    32'sh7FFF_FFFF, 1'b0);
    send_event(ssf_pkg::OP_TICK,        32'd3,    32'sh8000_0000, 1'b0);
    send_event(ssf_pkg::OP_TICK,        32'd4,    32'sd0,         1'b0);
    // degraded too long
    send_event(ssf_pkg::OP_TICK,        32'd5006, 32'sd77,        1'b0);
  endtask

  // Receiver holds off for a long counted stretch while beats keep coming,
  // so the block backs up and stalls its input; then the sender waits for
  // everything to drain.
  task automatic test_backpressure();
    wait_for_results();
    apply_settings(32'd1000, 32'd5000, 32'd500, 32'sd250, 32'd3, 32'd4);
    gap_pct     = 0;
    stall_pct   = 20;
    hold_cycles = 300;
    repeat (60) send_random_event();
    wait_for_results();
  endtask

  // Several register settings, extremes among them, each with random traffic.
  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          apply_settings(32'd1000, 32'd5000, 32'd500, '0, 32'd1, 32'd2);
          gap_pct = 25; stall_pct = 25;
        end
        1: begin
          // every timer fires at once
          apply_settings('0, '0, '0, 32'h7FFF_FFFF, 32'd65535, 32'd1);
          gap_pct = 40; stall_pct = 10;
        end
        2: begin
          // timers effectively never fire; zero numerator holds degraded drive at safe
          apply_settings('1, '1, '1, 32'h8000_0000, 32'd0, 32'd65535);
          gap_pct = 10; stall_pct = 40;
        end
        3: begin
          // no idling at all
          apply_settings($urandom_range(1, 300), $urandom_range(100, 3000),
                         $urandom_range(1, 500), $urandom,
                         $urandom_range(0, 65535), $urandom_range(1, 65535));
          gap_pct = 0; stall_pct = 0;
        end
        default: begin
          apply_settings(32'd200, 32'd2000, 32'd100, $urandom,
                         32'd65535, $urandom_range(1, 65535));
          gap_pct = 20; stall_pct = 20;
        end
      endcase
      repeat (110) send_random_event();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a forced hold of hold_cycles cycles
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst     = burst - 1;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        burst     = idle_length() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("result beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = verdicts_due.pop_front();
        check_field("new_state", 32'(new_state), 32'(want.state));
        check_field("actuation_allowed", 32'(actuation_allowed), 32'(want.allowed));
        check_field("drive_output", drive_output, want.drive);
        check_field("fault_flags", 32'(fault_flags), 32'(want.flags));
        check_field("rejected_count", rejected_count, want.rejected);
        check_field("transition_count", transition_count, want.transitions);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run limit: far above the slowest legal run
  // ---------------------------------------------------------------------------
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = '0;
    now_ms         = '0;
    desired_output = '0;
    carry_watchdog = 1'b0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatches     = 0;
    beats_seen     = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    hold_cycles    = 0;

    // register defaults and the reset state of the supervisor
    c_init_to = 32'd1000;
    c_deg_max = 32'd5000;
    c_recover = 32'd500;
    c_safe    = '0;
    c_num     = 16'd1;
    c_den     = 16'd2;
    clear_supervisor(1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_event_walk();
    test_degraded_clamp();
    test_backpressure();
    test_random_phases();
    wait_for_results();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/ssf_pkg.sv
src/ssf_regs.sv
src/ssf_ctrl.sv
src/ssf_clamp.sv
src/ssf_core.sv
src/safety_supervisor_fsm.sv
dv/tb_safety_supervisor_fsm.sv
